/* sv/mia_pkg.sv */
package mia_pkg;

  // fixed field widths
  localparam int DATA_W         = 16;
  localparam int ADDR_W         = 8;
  localparam int PRED_W         = 2;
  localparam int FRAC_BITS      = 8;
  localparam int FEATURE_FIELDS = 5;
  localparam int SCORE_FIELDS   = 4;

  // default network shape
  localparam int DEF_WEIGHT_DEPTH     = 256;
  localparam int DEF_INPUT_COUNT      = 5;
  localparam int DEF_HIDDEN_COUNT     = 15;
  localparam int DEF_OUTPUT_COUNT     = 4;
  localparam int DEF_CLASSES_COMPARED = 3;

  // width of an index into n entries, at least one bit
  function automatic int idx_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // one past the last word of the parameter layout
  function automatic int layout_end(int ni, int nh, int no);
    return 2 * ni * nh + nh + ni + ni * no + no;
  endfunction

  // layout address width, wide enough to compare against the store depth
  function automatic int layout_w(int depth, int ni, int nh, int no);
    return $clog2(max2(layout_end(ni, nh, no), depth) + 1);
  endfunction

  typedef enum logic [1:0] {
    LAYER_IN,
    LAYER_MID,
    LAYER_OUT
  } layer_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MAC,
    ST_DRAIN,
    ST_ARGMAX,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic   issue;
    logic   bias;
    logic   last;
    layer_e layer;
    logic   capture;
    logic   write;
    logic   argmax_init;
    logic   argmax_step;
    logic   load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } dp_status_t;

endpackage

/* sv/mlp_inference_argmax.sv */
// Three-layer linear perceptron with argmax. A transfer with command 0 writes one
// signed Q8.8 word into the weight and bias store (no result); a transfer
// with command 1 runs the network on five Q8.8 features and yields one result with
// the four saturated scores and the index of the largest of the first compared
// scores (lowest index on a tie). All multiply-accumulates go through one 16x16
// multiplier fed by the single read port of the store, one term per cycle while a
// layer is issued; an inference issues the three layers in turn, waits for the
// pipeline to drain after each layer, then steps the argmax and hands off the result.
// A finished result waits in the output register while the next transfer is taken in.
module mlp_inference_argmax #(
  parameter int WEIGHT_DEPTH     = mia_pkg::DEF_WEIGHT_DEPTH,
  parameter int INPUT_COUNT      = mia_pkg::DEF_INPUT_COUNT,
  parameter int HIDDEN_COUNT     = mia_pkg::DEF_HIDDEN_COUNT,
  parameter int OUTPUT_COUNT     = mia_pkg::DEF_OUTPUT_COUNT,
  parameter int CLASSES_COMPARED = mia_pkg::DEF_CLASSES_COMPARED
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  logic [mia_pkg::ADDR_W-1:0]         address_i,
  input  logic signed [mia_pkg::DATA_W-1:0]  value_i,
  input  logic signed [mia_pkg::DATA_W-1:0]  feature_0_i,
  input  logic signed [mia_pkg::DATA_W-1:0]  feature_1_i,
  input  logic signed [mia_pkg::DATA_W-1:0]  feature_2_i,
  input  logic signed [mia_pkg::DATA_W-1:0]  feature_3_i,
  input  logic signed [mia_pkg::DATA_W-1:0]  feature_4_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mia_pkg::PRED_W-1:0]         predicted_class_o,
  output logic signed [mia_pkg::DATA_W-1:0]  score_0_o,
  output logic signed [mia_pkg::DATA_W-1:0]  score_1_o,
  output logic signed [mia_pkg::DATA_W-1:0]  score_2_o,
  output logic signed [mia_pkg::DATA_W-1:0]  score_3_o
);
  import mia_pkg::*;

  localparam int LAY_W = layout_w(WEIGHT_DEPTH, INPUT_COUNT, HIDDEN_COUNT, OUTPUT_COUNT);
  localparam int I_W   = idx_w(max2(INPUT_COUNT, HIDDEN_COUNT));
  localparam int O_W   = idx_w(max2(max2(INPUT_COUNT, HIDDEN_COUNT), OUTPUT_COUNT));
  localparam int CMP   = (CLASSES_COMPARED < OUTPUT_COUNT) ? CLASSES_COMPARED
                                                            : OUTPUT_COUNT;
  localparam int CLS_W = idx_w(CMP);

  dp_cmd_t                  cmd;
  dp_status_t               status;
  logic [LAY_W-1:0]         rd_addr;
  logic [I_W-1:0]           x_idx;
  logic [O_W-1:0]           y_idx;
  logic [CLS_W-1:0]         cmp_idx;
  logic signed [DATA_W-1:0] features [FEATURE_FIELDS];
  logic signed [DATA_W-1:0] scores [SCORE_FIELDS];

  assign features[0] = feature_0_i;
  assign features[1] = feature_1_i;
  assign features[2] = feature_2_i;
  assign features[3] = feature_3_i;
  assign features[4] = feature_4_i;

  // sequencer
  mia_ctrl #(
    .WEIGHT_DEPTH     (WEIGHT_DEPTH),
    .INPUT_COUNT      (INPUT_COUNT),
    .HIDDEN_COUNT     (HIDDEN_COUNT),
    .OUTPUT_COUNT     (OUTPUT_COUNT),
    .CLASSES_COMPARED (CLASSES_COMPARED)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .x_idx_o     (x_idx),
    .y_idx_o     (y_idx),
    .cmp_idx_o   (cmp_idx)
  );

  // store, multiply-accumulate pipeline and result register
  mia_datapath #(
    .WEIGHT_DEPTH     (WEIGHT_DEPTH),
    .INPUT_COUNT      (INPUT_COUNT),
    .HIDDEN_COUNT     (HIDDEN_COUNT),
    .OUTPUT_COUNT     (OUTPUT_COUNT),
    .CLASSES_COMPARED (CLASSES_COMPARED)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .rd_addr_i (rd_addr),
    .x_idx_i   (x_idx),
    .y_idx_i   (y_idx),
    .cmp_idx_i (cmp_idx),
    .address_i (address_i),
    .value_i   (value_i),
    .feature_i (features),
    .pred_o    (predicted_class_o),
    .score_o   (scores)
  );

  assign score_0_o = scores[0];
  assign score_1_o = scores[1];
  assign score_2_o = scores[2];
  assign score_3_o = scores[3];

endmodule

/* sv/mia_ctrl.sv */
module mia_ctrl #(
  parameter int WEIGHT_DEPTH     = mia_pkg::DEF_WEIGHT_DEPTH,
  parameter int INPUT_COUNT      = mia_pkg::DEF_INPUT_COUNT,
  parameter int HIDDEN_COUNT     = mia_pkg::DEF_HIDDEN_COUNT,
  parameter int OUTPUT_COUNT     = mia_pkg::DEF_OUTPUT_COUNT,
  parameter int CLASSES_COMPARED = mia_pkg::DEF_CLASSES_COMPARED,
  localparam int LAY_W = mia_pkg::layout_w(WEIGHT_DEPTH, INPUT_COUNT, HIDDEN_COUNT,
                                           OUTPUT_COUNT),
  localparam int I_W   = mia_pkg::idx_w(mia_pkg::max2(INPUT_COUNT, HIDDEN_COUNT)),
  localparam int O_W   = mia_pkg::idx_w(mia_pkg::max2(mia_pkg::max2(INPUT_COUNT,
                                        HIDDEN_COUNT), OUTPUT_COUNT)),
  localparam int CMP   = (CLASSES_COMPARED < OUTPUT_COUNT) ? CLASSES_COMPARED
                                                            : OUTPUT_COUNT,
  localparam int CLS_W = mia_pkg::idx_w(CMP)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 command_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  mia_pkg::dp_status_t  status_i,
  output mia_pkg::dp_cmd_t     cmd_o,
  output logic [LAY_W-1:0]     rd_addr_o,
  output logic [I_W-1:0]       x_idx_o,
  output logic [O_W-1:0]       y_idx_o,
  output logic [CLS_W-1:0]     cmp_idx_o
);
  import mia_pkg::*;

  // layout bases
  localparam int W0_BASE = 0;
  localparam int B0_BASE = W0_BASE + INPUT_COUNT * HIDDEN_COUNT;
  localparam int W1_BASE = B0_BASE + HIDDEN_COUNT;
  localparam int B1_BASE = W1_BASE + HIDDEN_COUNT * INPUT_COUNT;
  localparam int W2_BASE = B1_BASE + INPUT_COUNT;
  localparam int B2_BASE = W2_BASE + INPUT_COUNT * OUTPUT_COUNT;

  state_e             state_q, state_d;
  layer_e             layer_q, layer_d;
  logic [O_W-1:0]     o_q, o_d;
  logic [I_W-1:0]     i_q, i_d;
  logic [LAY_W-1:0]   addr_q, addr_d;
  logic [CLS_W-1:0]   c_q, c_d;
  logic               out_valid_q, out_valid_d;

  logic [I_W-1:0]     nin_m1;
  logic [O_W-1:0]     nout_m1;
  logic [LAY_W-1:0]   nout_step;
  logic [LAY_W-1:0]   wbase;
  logic [LAY_W-1:0]   bbase;
  logic               last_mac;

  // shape of the current layer
  always_comb begin
    unique case (layer_q)
      LAYER_IN: begin
        nin_m1    = I_W'(INPUT_COUNT - 1);
        nout_m1   = O_W'(HIDDEN_COUNT - 1);
        nout_step = LAY_W'(HIDDEN_COUNT);
        wbase     = LAY_W'(W0_BASE);
        bbase     = LAY_W'(B0_BASE);
      end
      LAYER_MID: begin
        nin_m1    = I_W'(HIDDEN_COUNT - 1);
        nout_m1   = O_W'(INPUT_COUNT - 1);
        nout_step = LAY_W'(INPUT_COUNT);
        wbase     = LAY_W'(W1_BASE);
        bbase     = LAY_W'(B1_BASE);
      end
      LAYER_OUT: begin
        nin_m1    = I_W'(INPUT_COUNT - 1);
        nout_m1   = O_W'(OUTPUT_COUNT - 1);
        nout_step = LAY_W'(OUTPUT_COUNT);
        wbase     = LAY_W'(W2_BASE);
        bbase     = LAY_W'(B2_BASE);
      end
      default: begin
        nin_m1    = '0;
        nout_m1   = '0;
        nout_step = '0;
        wbase     = '0;
        bbase     = '0;
      end
    endcase
  end

  assign last_mac = (i_q == nin_m1);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      layer_q     <= LAYER_IN;
      o_q         <= '0;
      i_q         <= '0;
      addr_q      <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      layer_q     <= layer_d;
      o_q         <= o_d;
      i_q         <= i_d;
      addr_q      <= addr_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    layer_d     = layer_q;
    o_d         = o_q;
    i_d         = i_q;
    addr_d      = addr_q;
    c_d         = c_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o       = '0;
    cmd_o.layer = layer_q;
    rd_addr_o   = addr_q;
    x_idx_o     = i_q;
    y_idx_o     = o_q;
    cmp_idx_o   = c_q;
    in_ready_o  = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i) begin
            cmd_o.capture = 1'b1;
            layer_d       = LAYER_IN;
            o_d           = '0;
            state_d       = ST_BIAS;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_BIAS: begin
        cmd_o.issue = 1'b1;
        cmd_o.bias  = 1'b1;
        rd_addr_o   = bbase + LAY_W'(o_q);
        addr_d      = wbase + LAY_W'(o_q);
        i_d         = '0;
        state_d     = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        cmd_o.last  = last_mac;
        addr_d      = addr_q + nout_step;
        i_d         = i_q + 1'b1;
        if (last_mac) begin
          if (o_q == nout_m1) begin
            state_d = ST_DRAIN;
          end else begin
            o_d     = o_q + 1'b1;
            state_d = ST_BIAS;
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          unique case (layer_q)
            LAYER_IN: begin
              layer_d = LAYER_MID;
              o_d     = '0;
              state_d = ST_BIAS;
            end
            LAYER_MID: begin
              layer_d = LAYER_OUT;
              o_d     = '0;
              state_d = ST_BIAS;
            end
            default: begin
              cmd_o.argmax_init = 1'b1;
              c_d               = CLS_W'(1);
              state_d           = (CMP > 1) ? ST_ARGMAX : ST_DONE;
            end
          endcase
        end
      end
      ST_ARGMAX: begin
        cmd_o.argmax_step = 1'b1;
        if (c_q == CLS_W'(CMP - 1)) begin
          state_d = ST_DONE;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // store writes only between inferences
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> (state_q == ST_IDLE))
    else $error("store write outside idle");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // next layer starts only once the pipeline is empty
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d != ST_DRAIN) |-> !status_i.busy)
    else $error("layer left with work in flight");

endmodule

/* sv/mia_datapath.sv */
module mia_datapath #(
  parameter int WEIGHT_DEPTH     = mia_pkg::DEF_WEIGHT_DEPTH,
  parameter int INPUT_COUNT      = mia_pkg::DEF_INPUT_COUNT,
  parameter int HIDDEN_COUNT     = mia_pkg::DEF_HIDDEN_COUNT,
  parameter int OUTPUT_COUNT     = mia_pkg::DEF_OUTPUT_COUNT,
  parameter int CLASSES_COMPARED = mia_pkg::DEF_CLASSES_COMPARED,
  localparam int LAY_W = mia_pkg::layout_w(WEIGHT_DEPTH, INPUT_COUNT, HIDDEN_COUNT,
                                           OUTPUT_COUNT),
  localparam int I_W   = mia_pkg::idx_w(mia_pkg::max2(INPUT_COUNT, HIDDEN_COUNT)),
  localparam int O_W   = mia_pkg::idx_w(mia_pkg::max2(mia_pkg::max2(INPUT_COUNT,
                                        HIDDEN_COUNT), OUTPUT_COUNT)),
  localparam int CMP   = (CLASSES_COMPARED < OUTPUT_COUNT) ? CLASSES_COMPARED
                                                            : OUTPUT_COUNT,
  localparam int CLS_W = mia_pkg::idx_w(CMP)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mia_pkg::dp_cmd_t                    cmd_i,
  output mia_pkg::dp_status_t                 status_o,
  input  logic [LAY_W-1:0]                    rd_addr_i,
  input  logic [I_W-1:0]                      x_idx_i,
  input  logic [O_W-1:0]                      y_idx_i,
  input  logic [CLS_W-1:0]                    cmp_idx_i,
  input  logic [mia_pkg::ADDR_W-1:0]          address_i,
  input  logic signed [mia_pkg::DATA_W-1:0]   value_i,
  input  logic signed [mia_pkg::DATA_W-1:0]   feature_i [mia_pkg::FEATURE_FIELDS],
  output logic [mia_pkg::PRED_W-1:0]          pred_o,
  output logic signed [mia_pkg::DATA_W-1:0]   score_o [mia_pkg::SCORE_FIELDS]
);
  import mia_pkg::*;

  localparam int MEM_AW = idx_w(WEIGHT_DEPTH);
  localparam int FI_W   = idx_w(INPUT_COUNT);
  localparam int HI_W   = idx_w(HIDDEN_COUNT);
  localparam int S_W    = idx_w(OUTPUT_COUNT);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(max2(INPUT_COUNT, HIDDEN_COUNT) + 2);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(1 << (DATA_W - 1));

  // weight and bias store
  logic signed [DATA_W-1:0] mem [WEIGHT_DEPTH];

  // layer values
  logic signed [DATA_W-1:0] feat_q [INPUT_COUNT];
  logic signed [DATA_W-1:0] hid1_q [HIDDEN_COUNT];
  logic signed [DATA_W-1:0] hid2_q [INPUT_COUNT];
  logic signed [DATA_W-1:0] res_q  [OUTPUT_COUNT];

  // pipeline
  logic                     v1_q, v2_q, v3_q;
  logic                     bias1_q, last1_q, inr1_q;
  logic                     first2_q, last2_q;
  layer_e                   layer1_q, layer2_q, layer3_q;
  logic [I_W-1:0]           x1_q;
  logic [O_W-1:0]           y1_q, y2_q, y3_q;
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] w_sel, x_sel;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [DATA_W-1:0] acc_sat;
  logic                     wr_ok;

  // argmax and result
  logic [CLS_W-1:0]         best_q;
  logic signed [DATA_W-1:0] best_val_q;
  logic signed [DATA_W-1:0] cand;
  logic [PRED_W-1:0]        pred_q;
  logic signed [DATA_W-1:0] score_q [SCORE_FIELDS];

  assign wr_ok = (LAY_W'(address_i) < LAY_W'(WEIGHT_DEPTH));

  // store write port and registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_ok) begin
      mem[MEM_AW'(address_i)] <= value_i;
    end
    rdata_q <= mem[rd_addr_i[MEM_AW-1:0]];
  end

  // feature capture, beyond the feature fields the inputs are zero
  for (genvar g = 0; g < INPUT_COUNT; g++) begin : g_feat
    always_ff @(posedge clk_i) begin
      if (cmd_i.capture) begin
        if (g < FEATURE_FIELDS) begin
          feat_q[g] <= feature_i[(g < FEATURE_FIELDS) ? g : 0];
        end else begin
          feat_q[g] <= '0;
        end
      end
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q && last2_q;
    end
  end

  // stage 1: operand select
  assign w_sel = inr1_q ? rdata_q : '0;

  always_comb begin
    unique case (layer1_q)
      LAYER_IN:  x_sel = feat_q[x1_q[FI_W-1:0]];
      LAYER_MID: x_sel = hid1_q[x1_q[HI_W-1:0]];
      LAYER_OUT: x_sel = hid2_q[x1_q[FI_W-1:0]];
      default:   x_sel = '0;
    endcase
  end

  // bias is scaled by 256, weights multiply the input
  always_comb begin
    if (bias1_q) begin
      prod_d = {{(DATA_W - FRAC_BITS){w_sel[DATA_W-1]}}, w_sel, FRAC_BITS'(0)};
    end else begin
      prod_d = x_sel * w_sel;
    end
  end

  // stage 2: accumulate
  assign acc_d = first2_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  // stage 3: shift and saturate
  assign acc_shr = acc_q >>> FRAC_BITS;

  always_comb begin
    if (acc_shr > SAT_HI) begin
      acc_sat = SAT_HI[DATA_W-1:0];
    end else if (acc_shr < SAT_LO) begin
      acc_sat = SAT_LO[DATA_W-1:0];
    end else begin
      acc_sat = acc_shr[DATA_W-1:0];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    bias1_q  <= cmd_i.bias;
    last1_q  <= cmd_i.last;
    inr1_q   <= (rd_addr_i < LAY_W'(WEIGHT_DEPTH));
    layer1_q <= cmd_i.layer;
    x1_q     <= x_idx_i;
    y1_q     <= y_idx_i;
    prod_q   <= prod_d;
    first2_q <= bias1_q;
    last2_q  <= last1_q;
    layer2_q <= layer1_q;
    y2_q     <= y1_q;
    acc_q    <= acc_d;
    layer3_q <= layer2_q;
    y3_q     <= y2_q;
  end

  // write back the finished neuron
  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      unique case (layer3_q)
        LAYER_IN:  hid1_q[y3_q[HI_W-1:0]] <= acc_sat;
        LAYER_MID: hid2_q[y3_q[FI_W-1:0]] <= acc_sat;
        LAYER_OUT: res_q[y3_q[S_W-1:0]]   <= acc_sat;
        default: ;
      endcase
    end
  end

  // argmax over the compared scores, first maximum kept
  assign cand = res_q[S_W'(cmp_idx_i)];

  always_ff @(posedge clk_i) begin
    if (cmd_i.argmax_init) begin
      best_q     <= '0;
      best_val_q <= res_q[0];
    end else if (cmd_i.argmax_step && (cand > best_val_q)) begin
      best_q     <= cmp_idx_i;
      best_val_q <= cand;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pred_q <= PRED_W'(best_q);
    end
  end

  for (genvar k = 0; k < SCORE_FIELDS; k++) begin : g_score
    always_ff @(posedge clk_i) begin
      if (cmd_i.load_out) begin
        if (k < OUTPUT_COUNT) begin
          score_q[k] <= res_q[(k < OUTPUT_COUNT) ? k : 0];
        end else begin
          score_q[k] <= '0;
        end
      end
    end
    assign score_o[k] = score_q[k];
  end

  assign pred_o        = pred_q;
  assign status_o.busy = v1_q || v2_q || v3_q;

  // an issued read reaches the multiplier stage
  a_issue_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |=> v1_q)
    else $error("issued read lost");

  // an accumulate step always follows another step of the same neuron
  a_acc_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !first2_q) |-> $past(v2_q))
    else $error("accumulate without preceding term");

  // features are only taken in with the pipeline empty
  a_capture_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> !status_o.busy)
    else $error("features captured with work in flight");

endmodule
